@@ sv/ssys_pkg.sv @@
package ssys_pkg;

   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 16;
   localparam int STATE_W  = 32;
   localparam int PROD_W   = COEF_W + STATE_W;
   localparam int UPC_W    = 3;

   typedef enum logic [1:0] {
      ACT_WRITE   = 2'd0,
      ACT_PROCESS = 2'd1,
      ACT_CLEAR   = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } fsm_state_type;

   typedef enum logic [2:0] {
      OP_INIT,
      OP_MAC_X,
      OP_MAC_U,
      OP_ROW_END,
      OP_PHASE,
      OP_DRAIN,
      OP_COMMIT
   } op_type;

   typedef enum logic [2:0] {
      CND_NONE,
      CND_MORE_X,
      CND_MORE_U,
      CND_MORE_ROW,
      CND_OUT_PHASE,
      CND_BUSY,
      CND_OUT_FULL
   } cond_type;

   typedef struct packed {
      op_type           op;
      cond_type         cond;
      logic [UPC_W-1:0] target;
      logic             last;
   } uword_type;

   localparam logic [UPC_W-1:0] UPC_INIT    = 3'd0;
   localparam logic [UPC_W-1:0] UPC_MAC_X   = 3'd1;
   localparam logic [UPC_W-1:0] UPC_MAC_U   = 3'd2;
   localparam logic [UPC_W-1:0] UPC_ROW_END = 3'd3;
   localparam logic [UPC_W-1:0] UPC_PHASE   = 3'd4;
   localparam logic [UPC_W-1:0] UPC_DRAIN   = 3'd5;
   localparam logic [UPC_W-1:0] UPC_COMMIT  = 3'd6;

   // datapath strobes from the sequencer
   typedef struct packed {
      logic wr_en;
      logic clr;
      logic mac_x;
      logic mac_u;
      logic finish;
      logic dest_state;
      logic commit;
   } dp_ctl_type;

   // control carried down the multiply pipeline
   typedef struct packed {
      logic mac;
      logic fin;
      logic dst;
   } stage_type;

   function automatic uword_type ucode_rom(input logic [UPC_W-1:0] upc);
      uword_type uw;
      case (upc)
         UPC_INIT:    uw = '{OP_INIT,    CND_NONE,      UPC_MAC_X,   1'b0};
         UPC_MAC_X:   uw = '{OP_MAC_X,   CND_MORE_X,    UPC_MAC_X,   1'b0};
         UPC_MAC_U:   uw = '{OP_MAC_U,   CND_MORE_U,    UPC_MAC_U,   1'b0};
         UPC_ROW_END: uw = '{OP_ROW_END, CND_MORE_ROW,  UPC_MAC_X,   1'b0};
         UPC_PHASE:   uw = '{OP_PHASE,   CND_OUT_PHASE, UPC_MAC_X,   1'b0};
         UPC_DRAIN:   uw = '{OP_DRAIN,   CND_BUSY,      UPC_DRAIN,   1'b0};
         UPC_COMMIT:  uw = '{OP_COMMIT,  CND_OUT_FULL,  UPC_COMMIT,  1'b1};
         default:     uw = '{OP_DRAIN,   CND_NONE,      UPC_INIT,    1'b1};
      endcase
      return uw;
   endfunction

endpackage

@@ sv/ssys_intf.sv @@
interface ssys_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic [5:0]         coef_index;
   logic signed [15:0] coef_value;
   logic signed [15:0] in_first;
   logic signed [15:0] in_second;

   modport source (output valid, action, coef_index, coef_value, in_first, in_second,
                   input ready);
   modport sink (input valid, action, coef_index, coef_value, in_first, in_second,
                 output ready);
endinterface

interface ssys_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] out_first;
   logic signed [15:0] out_second;

   modport source (output valid, out_first, out_second, input ready);
   modport sink (input valid, out_first, out_second, output ready);
endinterface

@@ sv/ssys_datapath.sv @@
module ssys_datapath
   import ssys_pkg::*;
#(
   parameter int NUM_STATES         = 4,
   parameter int NUM_INPUTS         = 2,
   parameter int NUM_OUTPUTS        = 2,
   parameter int COEF_FRACTION_BITS = 12
) (
   input  logic                      clock,
   input  logic                      reset,
   input  dp_ctl_type                ctl,
   input  logic [5:0]                wr_idx,
   input  logic signed [COEF_W-1:0]  wr_val,
   input  logic [$clog2(NUM_STATES*NUM_STATES + NUM_STATES*NUM_INPUTS
                 + NUM_OUTPUTS*NUM_STATES + NUM_OUTPUTS*NUM_INPUTS)-1:0] rd_addr,
   input  logic [((NUM_STATES > 1) ? $clog2(NUM_STATES) : 1)-1:0] jx,
   input  logic [((NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1)-1:0] ju,
   input  logic [((NUM_STATES > 1) ? $clog2(NUM_STATES) : 1)-1:0] row,
   input  logic signed [SAMPLE_W-1:0] u0,
   input  logic signed [SAMPLE_W-1:0] u1,
   output logic                      busy,
   output logic signed [SAMPLE_W-1:0] y0,
   output logic signed [SAMPLE_W-1:0] y1
);

   localparam int DEPTH = NUM_STATES*NUM_STATES + NUM_STATES*NUM_INPUTS
                          + NUM_OUTPUTS*NUM_STATES + NUM_OUTPUTS*NUM_INPUTS;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int RW    = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
   localparam int ACC_W = PROD_W + $clog2(NUM_STATES + NUM_INPUTS);
   localparam int NYR   = (NUM_OUTPUTS < 2) ? NUM_OUTPUTS : 2;
   localparam int HALF_SH = (COEF_FRACTION_BITS > 0) ? COEF_FRACTION_BITS - 1 : 0;
   localparam logic signed [ACC_W:0] RND_HALF =
      (COEF_FRACTION_BITS > 0) ? ((ACC_W+1)'(1) <<< HALF_SH) : '0;
   localparam logic signed [ACC_W:0] Y_HI = (ACC_W+1)'(32767);
   localparam logic signed [ACC_W:0] Y_LO = (ACC_W+1)'(-32768);
   localparam logic signed [ACC_W:0] S_HI = (ACC_W+1)'(64'sh7FFF_FFFF);
   localparam logic signed [ACC_W:0] S_LO = (ACC_W+1)'(-64'sh8000_0000);

   // coefficient store
   logic signed [COEF_W-1:0]  coef_mem [DEPTH];
   logic [DEPTH-1:0]          coef_vld_ff, coef_vld_in;
   logic signed [COEF_W-1:0]  coef_rd_ff;
   logic                      coef_ok_ff;
   logic                      wr_hit;
   logic [PTR_W-1:0]          wr_addr;

   logic signed [STATE_W-1:0] x_ff [NUM_STATES];
   logic signed [STATE_W-1:0] x_in [NUM_STATES];
   logic signed [STATE_W-1:0] nx_ff [NUM_STATES];

   stage_type                 s1_ff, s1_in, s2_ff;
   logic [RW-1:0]             s1_row_ff, s2_row_ff;
   logic signed [STATE_W-1:0] opnd_ff, opnd_in;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [COEF_W-1:0]  coef_eff;

   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [ACC_W:0]     rnd, quo;
   logic signed [STATE_W-1:0] st_sat;
   logic signed [SAMPLE_W-1:0] y_sat;
   logic signed [SAMPLE_W-1:0] y0_ff, y1_ff;

   assign wr_hit  = ctl.wr_en && (int'(wr_idx) < DEPTH);
   assign wr_addr = PTR_W'(wr_idx);

   always_ff @(posedge clock) begin
      if (wr_hit) begin
         coef_mem[wr_addr] <= wr_val;
      end
      coef_rd_ff <= coef_mem[rd_addr];
      coef_ok_ff <= coef_vld_ff[rd_addr];
   end

   always_comb begin
      coef_vld_in = coef_vld_ff;
      if (wr_hit) begin
         coef_vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_vld_ff <= '0;
      end else begin
         coef_vld_ff <= coef_vld_in;
      end
   end

   // operand select and first stage
   always_comb begin
      s1_in.mac = ctl.mac_x || ctl.mac_u;
      s1_in.fin = ctl.finish;
      s1_in.dst = ctl.dest_state;
      if (ctl.mac_x) begin
         opnd_in = x_ff[jx];
      end else if (ju == '0) begin
         opnd_in = STATE_W'(u0);
      end else if ((NUM_INPUTS > 1) && (int'(ju) == 1)) begin
         opnd_in = STATE_W'(u1);
      end else begin
         opnd_in = '0;
      end
   end

   assign coef_eff = coef_ok_ff ? coef_rd_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
         s2_ff <= '0;
      end else begin
         s1_ff <= s1_in;
         s2_ff <= s1_ff;
      end
      s1_row_ff <= row;
      s2_row_ff <= s1_row_ff;
      opnd_ff   <= opnd_in;
      prod_ff   <= coef_eff * opnd_ff;
   end

   assign busy = s1_ff.mac || s1_ff.fin || s2_ff.mac || s2_ff.fin;

   // accumulate, round half up, saturate
   always_comb begin
      rnd = {acc_ff[ACC_W-1], acc_ff} + RND_HALF;
      quo = rnd >>> COEF_FRACTION_BITS;
      if (quo > S_HI) begin
         st_sat = STATE_W'(S_HI);
      end else if (quo < S_LO) begin
         st_sat = STATE_W'(S_LO);
      end else begin
         st_sat = quo[STATE_W-1:0];
      end
      if (quo > Y_HI) begin
         y_sat = SAMPLE_W'(Y_HI);
      end else if (quo < Y_LO) begin
         y_sat = SAMPLE_W'(Y_LO);
      end else begin
         y_sat = quo[SAMPLE_W-1:0];
      end
      if (s2_ff.fin) begin
         acc_in = '0;
      end else if (s2_ff.mac) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
      if (s2_ff.fin) begin
         if (s2_ff.dst) begin
            nx_ff[s2_row_ff] <= st_sat;
         end else if (s2_row_ff == '0) begin
            y0_ff <= y_sat;
         end else begin
            y1_ff <= y_sat;
         end
      end
   end

   // state vector
   always_comb begin
      for (int i = 0; i < NUM_STATES; i++) begin
         if (ctl.clr) begin
            x_in[i] = '0;
         end else if (ctl.commit) begin
            x_in[i] = nx_ff[i];
         end else begin
            x_in[i] = x_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_STATES; i++) begin
         if (reset) begin
            x_ff[i] <= '0;
         end else begin
            x_ff[i] <= x_in[i];
         end
      end
   end

   assign y0 = y0_ff;
   assign y1 = (NYR > 1) ? y1_ff : '0;

endmodule

@@ sv/state_space_system_step.sv @@
// process request: output rows (C, D) first, for R = min(NUM_OUTPUTS, 2) outputs, then
// state rows (A, B); the pipeline then drains and the response register is loaded
// one shared multiplier, one coefficient product per MAC-step cycle, one sample in flight
// next request taken the cycle after the response is loaded
// write and clear requests complete in the accepting cycle
// synchronous reset: sequencer idle, state vector zero, coefficient store reads zero
module state_space_system_step
   import ssys_pkg::*;
#(
   parameter int NUM_STATES         = 4,
   parameter int NUM_INPUTS         = 2,
   parameter int NUM_OUTPUTS        = 2,
   parameter int COEF_FRACTION_BITS = 12
) (
   input  logic              clock,
   input  logic              reset,
   ssys_req_if.sink          req_chan,
   ssys_rsp_if.source        rsp_chan
);

   localparam int BASE_A = 0;
   localparam int BASE_B = BASE_A + NUM_STATES*NUM_STATES;
   localparam int BASE_C = BASE_B + NUM_STATES*NUM_INPUTS;
   localparam int BASE_D = BASE_C + NUM_OUTPUTS*NUM_STATES;
   localparam int DEPTH  = BASE_D + NUM_OUTPUTS*NUM_INPUTS;
   localparam int PTR_W  = $clog2(DEPTH);
   localparam int XW     = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
   localparam int UW     = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
   localparam int RW     = XW;
   localparam int NYR    = (NUM_OUTPUTS < 2) ? NUM_OUTPUTS : 2;

   fsm_state_type state_ff, state_in;
   logic [UPC_W-1:0] upc_ff, upc_in;
   uword_type uw;
   logic cond_true;
   logic req_accept;
   action_type act;

   logic [XW-1:0]    jx_ff, jx_in;
   logic [UW-1:0]    ju_ff, ju_in;
   logic [RW-1:0]    row_ff, row_in, last_row;
   logic [PTR_W-1:0] ptr_x_ff, ptr_x_in, ptr_u_ff, ptr_u_in, rd_addr;
   logic             phase_out_ff, phase_out_in;
   logic signed [SAMPLE_W-1:0] u0_ff, u0_in, u1_ff, u1_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] out_first_ff, out_first_in, out_second_ff, out_second_in;

   dp_ctl_type ctl;
   logic dp_busy;
   logic signed [SAMPLE_W-1:0] y0, y1;

   assign uw         = ucode_rom(upc_ff);
   assign act        = action_type'(req_chan.action);
   assign req_accept = req_chan.valid && req_chan.ready;
   assign last_row   = phase_out_ff ? RW'(NYR - 1) : RW'(NUM_STATES - 1);

   always_comb begin
      case (uw.cond)
         CND_NONE:      cond_true = 1'b0;
         CND_MORE_X:    cond_true = (jx_ff != XW'(NUM_STATES - 1));
         CND_MORE_U:    cond_true = (ju_ff != UW'(NUM_INPUTS - 1));
         CND_MORE_ROW:  cond_true = (row_ff != last_row);
         CND_OUT_PHASE: cond_true = phase_out_ff;
         CND_BUSY:      cond_true = dp_busy;
         CND_OUT_FULL:  cond_true = rsp_valid_ff && !rsp_chan.ready;
         default:       cond_true = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (act == ACT_PROCESS)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (uw.last && !cond_true) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_chan.ready = 1'b0;
      ctl            = '0;
      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            ctl.wr_en      = req_accept && (act == ACT_WRITE);
            ctl.clr        = req_accept && (act == ACT_CLEAR);
         end
         ST_RUN: begin
            case (uw.op)
               OP_MAC_X:   ctl.mac_x = 1'b1;
               OP_MAC_U:   ctl.mac_u = 1'b1;
               OP_ROW_END: begin
                  ctl.finish     = 1'b1;
                  ctl.dest_state = !phase_out_ff;
               end
               OP_COMMIT:  ctl.commit = !cond_true;
               default:    ctl = '0;
            endcase
         end
         default: req_chan.ready = 1'b0;
      endcase
   end

   assign rd_addr = (uw.op == OP_MAC_U) ? ptr_u_ff : ptr_x_ff;

   // sequencer counters and pointers
   always_comb begin
      upc_in       = upc_ff;
      jx_in        = jx_ff;
      ju_in        = ju_ff;
      row_in       = row_ff;
      ptr_x_in     = ptr_x_ff;
      ptr_u_in     = ptr_u_ff;
      phase_out_in = phase_out_ff;
      u0_in        = u0_ff;
      u1_in        = u1_ff;
      if (state_ff == ST_IDLE) begin
         upc_in = UPC_INIT;
         if (req_accept && (act == ACT_PROCESS)) begin
            u0_in = req_chan.in_first;
            u1_in = req_chan.in_second;
         end
      end else begin
         upc_in = cond_true ? uw.target : upc_ff + UPC_W'(1);
         case (uw.op)
            OP_INIT: begin
               jx_in        = '0;
               ju_in        = '0;
               row_in       = '0;
               phase_out_in = 1'b1;
               ptr_x_in     = PTR_W'(BASE_C);
               ptr_u_in     = PTR_W'(BASE_D);
            end
            OP_MAC_X: begin
               ptr_x_in = ptr_x_ff + PTR_W'(1);
               jx_in    = cond_true ? jx_ff + XW'(1) : '0;
            end
            OP_MAC_U: begin
               ptr_u_in = ptr_u_ff + PTR_W'(1);
               ju_in    = cond_true ? ju_ff + UW'(1) : '0;
            end
            OP_ROW_END: begin
               row_in = cond_true ? row_ff + RW'(1) : '0;
            end
            OP_PHASE: begin
               if (phase_out_ff) begin
                  phase_out_in = 1'b0;
                  ptr_x_in     = PTR_W'(BASE_A);
                  ptr_u_in     = PTR_W'(BASE_B);
               end
            end
            default: ;
         endcase
      end
   end

   // response register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      out_first_in  = out_first_ff;
      out_second_in = out_second_ff;
      if (ctl.commit) begin
         rsp_valid_in  = 1'b1;
         out_first_in  = y0;
         out_second_in = y1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         upc_ff       <= UPC_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         upc_ff       <= upc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      jx_ff         <= jx_in;
      ju_ff         <= ju_in;
      row_ff        <= row_in;
      ptr_x_ff      <= ptr_x_in;
      ptr_u_ff      <= ptr_u_in;
      phase_out_ff  <= phase_out_in;
      u0_ff         <= u0_in;
      u1_ff         <= u1_in;
      out_first_ff  <= out_first_in;
      out_second_ff <= out_second_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.out_first  = out_first_ff;
   assign rsp_chan.out_second = out_second_ff;

   ssys_datapath #(
      .NUM_STATES         (NUM_STATES),
      .NUM_INPUTS         (NUM_INPUTS),
      .NUM_OUTPUTS        (NUM_OUTPUTS),
      .COEF_FRACTION_BITS (COEF_FRACTION_BITS)
   ) u_datapath (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .wr_idx  (req_chan.coef_index),
      .wr_val  (req_chan.coef_value),
      .rd_addr (rd_addr),
      .jx      (jx_ff),
      .ju      (ju_ff),
      .row     (row_ff),
      .u0      (u0_ff),
      .u1      (u1_ff),
      .busy    (dp_busy),
      .y0      (y0),
      .y1      (y1)
   );

   a_commit_drained: assert property (@(posedge clock) disable iff (reset)
      ctl.commit |-> !dp_busy)
      else $error("response loaded with products still in flight");

   a_upc_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (upc_ff <= UPC_COMMIT))
      else $error("step counter left the program");

   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctl.commit))
      else $error("response raised without a commit step");

   a_no_request_in_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> !ctl.wr_en && !ctl.clr)
      else $error("store or state changed during a sample");

endmodule
